>>> rtl/column_rle_pixel_decoder_assert.svh
// Assertion macros used by the column RLE pixel decoder sequencer RTL.
// No dependencies; include by bare file name.
`ifndef COLUMN_RLE_PIXEL_DECODER_ASSERT_SVH
`define COLUMN_RLE_PIXEL_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define CRLD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("crld assertion failed");

// Next-cycle implication, checked out of reset
`define CRLD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("crld assertion failed");

`endif

>>> rtl/crld_pkg.sv
// Shared types and constants for the column RLE pixel decoder.
// No dependencies.
package crld_pkg;

    localparam int LANES_OUT   = 8;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = 24;
    localparam logic [7:0] RUN_BASE = 8'd128;

    // configuration register indexes
    localparam logic CFG_TRANSPARENT = 1'b0;
    localparam logic CFG_LIMIT       = 1'b1;

    // pixel fill requested by one input word
    typedef struct packed {
        logic [7:0] n;
        logic [7:0] v;
    } crld_fill_t;

    // operands and result of the shared subtractor
    typedef struct packed {
        logic [CNT_W-1:0] a;
        logic [CNT_W-1:0] b;
    } crld_alu_op_t;

    typedef struct packed {
        logic [CNT_W-1:0] diff;
        logic             borrow;
    } crld_alu_res_t;

endpackage

>>> rtl/crld_alu.sv
// Shared 24-bit subtractor with borrow, used by the sequencer in every state but idle.
// Depends on crld_pkg.
module crld_alu (
    input  crld_pkg::crld_alu_op_t  op,
    output crld_pkg::crld_alu_res_t res
);
    import crld_pkg::*;

    logic [CNT_W:0] wide;

    // subtract with one extra bit to catch the borrow
    always_comb begin
        wide       = {1'b0, op.a} - {1'b0, op.b};
        res.diff   = wide[CNT_W-1:0];
        res.borrow = wide[CNT_W];
    end

endmodule

>>> rtl/crld_parse.sv
// Byte parser: control, literal and run value phases of the compressed stream.
// Depends on crld_pkg.
module crld_parse (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    input  logic                 column_end,
    input  logic                 image_start,
    input  logic                 transparent_mode,
    output crld_pkg::crld_fill_t fill
);
    import crld_pkg::*;

    typedef enum logic [1:0] {
        PH_CTRL = 2'd0,
        PH_LIT  = 2'd1,
        PH_REP  = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next, phase_eff;
    logic [7:0] lit_reg, lit_next, lit_eff;
    logic [6:0] rep_reg, rep_next, rep_eff;

    // decode the current word against the parser phase
    always_comb begin
        phase_eff  = image_start ? PH_CTRL : phase_reg;
        lit_eff    = image_start ? 8'd0 : lit_reg;
        rep_eff    = image_start ? 7'd0 : rep_reg;
        fill.n     = 8'd0;
        fill.v     = data_byte;
        phase_next = phase_eff;
        lit_next   = lit_eff;
        rep_next   = rep_eff;
        case (phase_eff)
            PH_LIT: begin
                fill.n     = 8'd1;
                lit_next   = lit_eff - 8'd1;
                phase_next = (lit_next == 8'd0) ? PH_CTRL : PH_LIT;
            end
            PH_REP: begin
                fill.n     = {1'b0, rep_eff};
                rep_next   = 7'd0;
                phase_next = PH_CTRL;
            end
            default: begin
                phase_next = PH_CTRL;
                if (data_byte <= RUN_BASE) begin
                    if (data_byte != 8'd0) begin
                        phase_next = PH_LIT;
                        lit_next   = data_byte;
                    end
                end else if (transparent_mode) begin
                    fill.n = data_byte - RUN_BASE;
                    fill.v = 8'd0;
                end else begin
                    phase_next = PH_REP;
                    rep_next   = data_byte[6:0];
                end
            end
        endcase
        // drop anything pending at the end of a column
        if (column_end) begin
            phase_next = PH_CTRL;
            lit_next   = 8'd0;
            rep_next   = 7'd0;
        end
    end

    // hold parser state, advance on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_CTRL;
            lit_reg   <= 8'd0;
            rep_reg   <= 7'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            lit_reg   <= lit_next;
            rep_reg   <= rep_next;
        end
    end

endmodule

>>> rtl/crld_seq.sv
// Sequencer: clamps each fill to the pixel limit and emits packed groups
// through the output register. Depends on crld_pkg, the assertion header and the shared subtractor.
`include "column_rle_pixel_decoder_assert.svh"

module crld_seq (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic                    image_start,
    input  crld_pkg::crld_fill_t    fill,
    input  logic [23:0]             pixel_limit,
    input  crld_pkg::crld_alu_res_t alu_res,
    output crld_pkg::crld_alu_op_t  alu_op,
    output logic                    busy,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [63:0]             m_pixels,
    output logic [3:0]              m_pixel_count,
    output logic                    m_run_last,
    output logic                    m_limit_hit
);
    import crld_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_AVAIL = 3'd1,
        S_CLAMP = 3'd2,
        S_EMIT  = 3'd3,
        S_TOTAL = 3'd4
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] avail_reg, avail_next;
    logic [7:0]       left_reg, left_next;
    logic [7:0]       fill_n_reg, fill_n_next;
    logic [7:0]       fill_v_reg, fill_v_next;
    logic [4:0]       nres_reg, nres_next;
    logic             valid_reg, valid_next;
    logic [63:0]      pix_reg, pix_next;
    logic [3:0]       count_reg, count_next;
    logic             last_reg, last_next;
    logic             hit_reg, hit_next;

    logic             out_free;
    logic [3:0]       grp;
    logic [7:0]       left_after;
    logic             grp_last;
    logic [63:0]      grp_pix;

    assign out_free = !valid_reg || m_ready;

    // group size and packed pixels for the current step
    always_comb begin
        grp = (left_reg < 8'(LANES_OUT)) ? left_reg[3:0] : 4'(LANES_OUT);
        left_after = left_reg - {4'd0, grp};
        grp_last = (left_after == 8'd0) || (nres_reg == 5'(MAX_RESULTS - 1));
        grp_pix = 64'd0;
        for (int i = 0; i < LANES_OUT; i++) begin
            if (4'(i) < grp) begin
                grp_pix[8*i +: 8] = fill_v_reg;
            end
        end
    end

    // route operands to the shared subtractor
    always_comb begin
        alu_op.a = pixel_limit;
        alu_op.b = total_reg;
        case (state_reg)
            S_CLAMP: begin
                alu_op.a = {16'd0, fill_n_reg};
                alu_op.b = avail_reg;
            end
            S_EMIT: begin
                alu_op.a = avail_reg;
                alu_op.b = {20'd0, grp};
            end
            S_TOTAL: begin
                alu_op.a = pixel_limit;
                alu_op.b = avail_reg;
            end
            default: begin
                alu_op.a = pixel_limit;
                alu_op.b = total_reg;
            end
        endcase
    end

    // step the sequencer
    always_comb begin
        state_next  = state_reg;
        total_next  = total_reg;
        avail_next  = avail_reg;
        left_next   = left_reg;
        fill_n_next = fill_n_reg;
        fill_v_next = fill_v_reg;
        nres_next   = nres_reg;
        valid_next  = valid_reg && !m_ready;
        pix_next    = pix_reg;
        count_next  = count_reg;
        last_next   = last_reg;
        hit_next    = hit_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    fill_n_next = fill.n;
                    fill_v_next = fill.v;
                    if (image_start) begin
                        total_next = '0;
                    end
                    if (fill.n != 8'd0) begin
                        state_next = S_AVAIL;
                    end
                end
            end
            S_AVAIL: begin
                avail_next = alu_res.borrow ? '0 : alu_res.diff;
                state_next = S_CLAMP;
            end
            S_CLAMP: begin
                left_next  = alu_res.borrow ? fill_n_reg : avail_reg[7:0];
                nres_next  = 5'd0;
                state_next = (left_next == 8'd0) ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    pix_next   = grp_pix;
                    count_next = grp;
                    last_next  = grp_last;
                    hit_next   = (alu_res.diff == '0);
                    avail_next = alu_res.diff;
                    left_next  = left_after;
                    nres_next  = nres_reg + 5'd1;
                    if (grp_last) begin
                        state_next = S_TOTAL;
                    end
                end
            end
            S_TOTAL: begin
                total_next = alu_res.diff;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold state and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            total_reg <= total_next;
            valid_reg <= valid_next;
        end
        avail_reg  <= avail_next;
        left_reg   <= left_next;
        fill_n_reg <= fill_n_next;
        fill_v_reg <= fill_v_next;
        nres_reg   <= nres_next;
        pix_reg    <= pix_next;
        count_reg  <= count_next;
        last_reg   <= last_next;
        hit_reg    <= hit_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign m_valid       = valid_reg;
    assign m_pixels      = pix_reg;
    assign m_pixel_count = count_reg;
    assign m_run_last    = last_reg;
    assign m_limit_hit   = hit_reg;

    `CRLD_ASSERT_IMP(a_count_range, aclk, aresetn, valid_reg, (count_reg != 4'd0) && (count_reg <= 4'(LANES_OUT)))
    `CRLD_ASSERT_IMP(a_left_within_avail, aclk, aresetn, state_reg == S_EMIT, ({16'd0, left_reg} <= avail_reg))
    `CRLD_ASSERT_NXT(a_last_then_total, aclk, aresetn, (state_reg == S_EMIT) && out_free && grp_last, state_reg == S_TOTAL)
    `CRLD_ASSERT_IMP(a_total_in_range, aclk, aresetn, state_reg == S_TOTAL, !alu_res.borrow)

endmodule

>>> rtl/column_rle_pixel_decoder.sv
// Column RLE pixel decoder. A word that gives no pixels leaves the sequencer idle; one that
// does takes limit and clamp steps, stopping if the limit cuts it to nothing, else an emit
// step per group of up to eight (1 to 16) and a total step. Words are taken only while
// idle. The single shared 24-bit subtractor does one limit, clamp or count step a cycle
// unless the output stalls. Synchronous active-low reset clears parser, sequencer state
// and pixel total, and sets transparent_mode to 0 and pixel_limit to all ones.
module column_rle_pixel_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [23:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_column_end,
    input  logic        s_image_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_pixels,
    output logic [3:0]  m_pixel_count,
    output logic        m_run_last,
    output logic        m_limit_hit
);
    import crld_pkg::*;

    logic          transparent_reg;
    logic [23:0]   limit_reg;
    logic          accept;
    logic          busy;
    crld_fill_t    fill;
    crld_alu_op_t  alu_op;
    crld_alu_res_t alu_res;

    // take configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            transparent_reg <= 1'b0;
            limit_reg       <= 24'hFFFFFF;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TRANSPARENT: transparent_reg <= cfg_wdata[0];
                CFG_LIMIT:       limit_reg       <= cfg_wdata;
                default:         limit_reg       <= limit_reg;
            endcase
        end
    end

    assign s_ready = !busy;
    assign accept  = s_valid && s_ready;

    crld_parse u_parse (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (accept),
        .data_byte        (s_data_byte),
        .column_end       (s_column_end),
        .image_start      (s_image_start),
        .transparent_mode (transparent_reg),
        .fill             (fill)
    );

    crld_alu u_alu (
        .op  (alu_op),
        .res (alu_res)
    );

    crld_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (accept),
        .image_start   (s_image_start),
        .fill          (fill),
        .pixel_limit   (limit_reg),
        .alu_res       (alu_res),
        .alu_op        (alu_op),
        .busy          (busy),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixels      (m_pixels),
        .m_pixel_count (m_pixel_count),
        .m_run_last    (m_run_last),
        .m_limit_hit   (m_limit_hit)
    );

endmodule

>>> bench/column_rle_pixel_decoder_tb.sv
// Self-checking testbench for the column RLE pixel decoder: directed and random byte streams,
// random stalls on both channels, pixel groups predicted in the bench and checked in order.
// Depends on crld_pkg and the column_rle_pixel_decoder RTL only.
module column_rle_pixel_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crld_pkg::*;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          IDLE_PCT      = 36;
    localparam logic [23:0] LIMIT_MAX     = 24'hFFFFFF;

    // parser phase as the bench tracks it
    typedef enum logic [1:0] {
        WAIT_CTRL  = 2'd0,
        IN_LITERAL = 2'd1,
        IN_RUN     = 2'd2
    } parse_phase_e;

    // one packed group of pixels leaving the block
    typedef struct packed {
        logic [63:0] pixels;
        logic [3:0]  count;
        logic        run_last;
        logic        limit_hit;
    } pix_group_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [23:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_column_end;
    logic        s_image_start;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_pixels;
    logic [3:0]  m_pixel_count;
    logic        m_run_last;
    logic        m_limit_hit;

    // bench copy of the decoder state and registers
    parse_phase_e phase_now;
    logic [7:0]   literals_due;
    logic [6:0]   run_length;
    logic [23:0]  pixels_emitted;
    logic         zero_runs;
    logic [23:0]  limit_now;

    pix_group_t pixel_groups_due[$];
    pix_group_t want_grp;
    pix_group_t seen_grp;
    int         mismatches = 0;
    logic       steady = 1'b0;

    column_rle_pixel_decoder DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_column_end  (s_column_end),
        .s_image_start (s_image_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixels      (m_pixels),
        .m_pixel_count (m_pixel_count),
        .m_run_last    (m_run_last),
        .m_limit_hit   (m_limit_hit)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // stall the result side at random, except during the steady stretch
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // compare each taken result word with the oldest expected group
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_grp = '{m_pixels, m_pixel_count, m_run_last, m_limit_hit};
            if (pixel_groups_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: pixels=%h count=%0d last=%b hit=%b",
                             seen_grp.pixels, seen_grp.count, seen_grp.run_last,
                             seen_grp.limit_hit);
            end else begin
                want_grp = pixel_groups_due.pop_front();
                if (seen_grp.pixels !== want_grp.pixels || seen_grp.count !== want_grp.count ||
                    seen_grp.run_last !== want_grp.run_last ||
                    seen_grp.limit_hit !== want_grp.limit_hit) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected pixels=%h count=%0d last=%b hit=%b, got pixels=%h count=%0d last=%b hit=%b",
                                 want_grp.pixels, want_grp.count, want_grp.run_last,
                                 want_grp.limit_hit, seen_grp.pixels, seen_grp.count,
                                 seen_grp.run_last, seen_grp.limit_hit);
                end
            end
        end
    end

    // watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("FAIL column_rle_pixel_decoder");
        $finish;
    end

    function automatic void clear_parse();
        phase_now    = WAIT_CTRL;
        literals_due = '0;
        run_length   = '0;
    endfunction

    // work out the pixel groups that one accepted word gives
    function automatic void decode_word(input logic [7:0] b, input logic ce, input logic is);
        int unsigned fill_n;
        int unsigned avail;
        int unsigned left;
        int unsigned g;
        logic [7:0]  fill_v;
        int          grp;
        pix_group_t  pg;
        fill_n = 0;
        fill_v = '0;
        grp    = 0;
        if (is) begin
            pixels_emitted = '0;
            clear_parse();
        end
        case (phase_now)
            IN_LITERAL: begin
                fill_n       = 1;
                fill_v       = b;
                literals_due = literals_due - 8'd1;
                if (literals_due == 8'd0)
                    phase_now = WAIT_CTRL;
            end
            IN_RUN: begin
                fill_n     = run_length;
                fill_v     = b;
                run_length = '0;
                phase_now  = WAIT_CTRL;
            end
            default: begin
                phase_now = WAIT_CTRL;
                if (b <= RUN_BASE) begin
                    if (b != 8'd0) begin
                        phase_now    = IN_LITERAL;
                        literals_due = b;
                    end
                end else if (zero_runs) begin
                    fill_n = b - RUN_BASE;
                end else begin
                    phase_now  = IN_RUN;
                    run_length = 7'(b - RUN_BASE);
                end
            end
        endcase
        // clamp to what the limit still allows
        avail = (limit_now > pixels_emitted) ? limit_now - pixels_emitted : 0;
        left  = (fill_n < avail) ? fill_n : avail;
        while (left > 0 && grp < MAX_RESULTS) begin
            g = (left < LANES_OUT) ? left : LANES_OUT;
            pg.pixels = '0;
            for (int i = 0; i < int'(g); i++)
                pg.pixels[8*i +: 8] = fill_v;
            pixels_emitted = pixels_emitted + 24'(g);
            left           = left - g;
            pg.count       = 4'(g);
            pg.run_last    = (left == 0) || (grp == MAX_RESULTS - 1);
            pg.limit_hit   = (pixels_emitted >= limit_now);
            pixel_groups_due.push_back(pg);
            grp++;
        end
        if (ce)
            clear_parse();
    endfunction

    // offer one word, with a random gap in front, and predict it once taken
    task automatic send_word(input logic [7:0] b, input logic ce, input logic is);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < IDLE_PCT);
        end
        s_valid       <= 1'b1;
        s_data_byte   <= b;
        s_column_end  <= ce;
        s_image_start <= is;
        do @(posedge aclk); while (!s_ready);
        decode_word(b, ce, is);
    endtask

    // drop valid, wait for every expected word, then let the block settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pixel_groups_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write both registers on consecutive edges; only while idle
    task automatic write_config(input logic mode, input logic [23:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TRANSPARENT;
        cfg_wdata <= {23'd0, mode};
        @(posedge aclk);
        zero_runs <= mode;
        cfg_index <= CFG_LIMIT;
        cfg_wdata <= limit;
        @(posedge aclk);
        limit_now <= limit;
        cfg_we    <= 1'b0;
    endtask

    // one stream fragment: mostly well formed, some noise and cut-short runs
    task automatic send_fragment(input logic force_start, inout int sent);
        int   r;
        int   n;
        logic is;
        logic ce;
        r  = $urandom_range(99);
        is = force_start || ($urandom_range(99) < 8);
        if (r < 12) begin
            send_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
            sent++;
        end else if (r < 60) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            send_word(8'(n), 1'b0, is);
            sent++;
            for (int k = 0; k < n; k++) begin
                ce = (k == n - 1) ? 1'($urandom_range(1)) : ($urandom_range(99) < 4);
                send_word(8'($urandom_range(255)), ce, 1'b0);
                sent++;
                if (ce)
                    break;
            end
        end else begin
            ce = ($urandom_range(99) < 10);
            send_word(8'($urandom_range(129, 255)), zero_runs ? 1'($urandom_range(1)) : ce, is);
            sent++;
            if (!zero_runs && !ce) begin
                send_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
                sent++;
            end
        end
    endtask

    task automatic run_phase(input logic mode, input logic [23:0] limit, input int target,
                             input logic pause_midway);
        int   sent;
        logic paused;
        sent   = 0;
        paused = 1'b0;
        wait_idle();
        write_config(mode, limit);
        send_fragment(1'b1, sent);
        while (sent < target) begin
            // hold off until the block has drained completely
            if (pause_midway && !paused && sent >= target / 2) begin
                wait_idle();
                paused = 1'b1;
            end
            send_fragment(1'b0, sent);
        end
    endtask

    // literals, empty control, the longest run, column end and image start mid-stream
    task automatic test_literals_and_runs();
        send_word(8'd0, 1'b0, 1'b1);
        send_word(8'd3, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'hA5, 1'b0, 1'b0);
        send_word(8'd128, 1'b0, 1'b0);
        send_word(8'h5A, 1'b0, 1'b0);
        send_word(8'h81, 1'b1, 1'b0);
        send_word(8'd255, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'd200, 1'b1, 1'b0);
        send_word(8'd130, 1'b0, 1'b0);
        send_word(8'h11, 1'b0, 1'b0);
        send_word(8'd5, 1'b0, 1'b0);
        send_word(8'h01, 1'b0, 1'b0);
        send_word(8'd1, 1'b0, 1'b1);
        send_word(8'h7E, 1'b0, 1'b0);
    endtask

    // switch to transparent between a run control word and its value word
    task automatic test_mode_switch();
        send_word(8'd140, 1'b0, 1'b0);
        wait_idle();
        write_config(1'b1, LIMIT_MAX);
        send_word(8'h99, 1'b0, 1'b0);
        send_word(8'd255, 1'b1, 1'b0);
        send_word(8'd129, 1'b0, 1'b0);
    endtask

    // clamp at the limit, limit below the total, and a zero limit
    task automatic test_pixel_limit();
        wait_idle();
        write_config(1'b0, 24'd10);
        send_word(8'd255, 1'b0, 1'b1);
        send_word(8'h42, 1'b0, 1'b0);
        wait_idle();
        write_config(1'b0, 24'd4);
        send_word(8'd1, 1'b0, 1'b0);
        send_word(8'h33, 1'b0, 1'b0);
        wait_idle();
        write_config(1'b1, 24'd0);
        send_word(8'd1, 1'b0, 1'b1);
        send_word(8'h44, 1'b0, 1'b0);
    endtask

    task automatic test_random_streams();
        run_phase(1'b0, LIMIT_MAX, 48, 1'b0);
        // no idling on either side for this stretch
        steady = 1'b1;
        run_phase(1'b1, LIMIT_MAX, 48, 1'b0);
        steady = 1'b0;
        run_phase(1'b0, 24'($urandom_range(40, 400)), 48, 1'b1);
        run_phase(1'b1, 24'($urandom_range(1, 120)), 48, 1'b0);
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_TRANSPARENT;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_data_byte   = '0;
        s_column_end  = 1'b0;
        s_image_start = 1'b0;
        m_ready       = 1'b0;
        zero_runs      = 1'b0;
        limit_now      = LIMIT_MAX;
        pixels_emitted = '0;
        clear_parse();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_literals_and_runs();
        test_mode_switch();
        test_pixel_limit();
        test_random_streams();

        wait_idle();
        if (mismatches == 0 && pixel_groups_due.size() == 0)
            $display("PASS column_rle_pixel_decoder");
        else
            $display("FAIL column_rle_pixel_decoder");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/crld_pkg.sv
rtl/crld_alu.sv
rtl/crld_parse.sv
rtl/crld_seq.sv
rtl/column_rle_pixel_decoder.sv
bench/column_rle_pixel_decoder_tb.sv
